// File: rtl/ssp_pkg.sv
package ssp_pkg;

    // Digit limit for the leading decimal number
    localparam int unsigned MaxDigits = 20;

    // Result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_DIGITS   = 3'd1;
    localparam logic [2:0] ST_BAD_SUFFIX  = 3'd2;
    localparam logic [2:0] ST_SUFFIX_LONG = 3'd3;
    localparam logic [2:0] ST_OVERFLOW    = 3'd4;

    // One request in flight through the scaling pipeline
    typedef struct packed {
        logic [63:0] value;      // running product, zero on error
        logic [2:0]  status;
        logic [2:0]  steps;      // scaling steps still to apply
        logic        base_1000;  // 1: scale by 1000, 0: scale by 1024
    } t_stage;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // Power of the unit letter: k=1, m=2, g=3, t=4, anything else 0
    function automatic logic [2:0] unit_steps(input logic [7:0] letter);
        logic [2:0] r;
        case (letter)
            8'h6b:   r = 3'd1;
            8'h6d:   r = 3'd2;
            8'h67:   r = 3'd3;
            8'h74:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/ssp_scale_stage.sv
module ssp_scale_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ssp_pkg::t_stage i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output ssp_pkg::t_stage o_data
);
    import ssp_pkg::*;

    logic   r_valid;
    t_stage r_data;
    t_stage n_data;
    logic [73:0] x;
    logic [73:0] prod;

    // Stage takes a request when empty or when its content moves on
    assign o_ready = !r_valid || i_ready;

    // When steps remain, one multiply by 1000 or 1024 as shifts and subtracts, overflow from the top bits
    always_comb begin
        x = {10'b0, i_data.value};
        if (i_data.base_1000) begin
            prod = (x << 10) - (x << 4) - (x << 3);
        end else begin
            prod = x << 10;
        end
        n_data = i_data;
        if (i_data.steps != 3'd0) begin
            n_data.steps = i_data.steps - 3'd1;
            if (prod[73:64] != 10'b0) begin
                n_data.value  = 64'd0;
                n_data.status = ST_OVERFLOW;
                n_data.steps  = 3'd0;
            end else begin
                n_data.value = prod[63:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/size_string_parser.sv
// Size string parser: takes a size string such as "12", "4k" or "3GB" one
// character per request (i_is_end marks the terminator) and answers each
// terminator with the value in bytes and a status (0 ok, 1 no digits,
// 2 unknown suffix, 3 suffix too long, 4 overflow; value is zero unless ok).
// Characters are taken one per cycle, with no gaps while nothing stalls; a new
// string may start in the cycle after its predecessor's terminator. The result
// of a string passes through one decode register, four scaling stages, each
// applying at most one factor of 1000 or 1024, and then the output register.
// Backpressure on the result side stalls the pipeline and, once it is full, the
// input side.
module size_string_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_is_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_size_value,
    output logic [2:0]  o_status
);
    import ssp_pkg::*;

    localparam int NumStages = 4;

    // String state
    logic        r_in_suffix;
    logic [63:0] r_accum;
    logic        r_accum_ovf;
    logic [4:0]  r_digit_count;
    logic [1:0]  r_suffix_len;
    logic [7:0]  r_suffix_chars [2];

    logic        take;
    logic        is_digit;
    logic [67:0] acc_wide;
    t_stage      n_p0;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [2:0]  steps0;

    logic [NumStages:0] stg_valid;
    logic [NumStages:0] stg_ready;
    t_stage             stg_data [NumStages+1];
    logic               r_p0_valid;
    t_stage             r_p0;
    logic               out_valid;
    logic               out_ready;
    t_stage             r_out;
    logic               r_out_valid;

    assign o_ready = !r_p0_valid || stg_ready[0];
    assign take    = i_valid && o_ready;

    // Digit accumulate: accum*10 + d, overflow when the top bits are set
    assign is_digit = !r_in_suffix && (r_digit_count < 5'(MaxDigits)) &&
                      (i_ch >= 8'h30) && (i_ch <= 8'h39);
    assign acc_wide = ({4'b0, r_accum} << 3) + ({4'b0, r_accum} << 1) +
                      68'(i_ch - 8'h30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_suffix   <= 1'b0;
            r_accum       <= 64'd0;
            r_accum_ovf   <= 1'b0;
            r_digit_count <= 5'd0;
            r_suffix_len  <= 2'd0;
        end else if (take) begin
            if (i_is_end) begin
                r_in_suffix   <= 1'b0;
                r_accum       <= 64'd0;
                r_accum_ovf   <= 1'b0;
                r_digit_count <= 5'd0;
                r_suffix_len  <= 2'd0;
            end else if (is_digit) begin
                if (acc_wide[67:64] != 4'b0) begin
                    r_accum_ovf <= 1'b1;
                    r_accum     <= '1;
                end else begin
                    r_accum <= acc_wide[63:0];
                end
                r_digit_count <= r_digit_count + 5'd1;
            end else begin
                r_in_suffix <= 1'b1;
                if (r_suffix_len != 2'd3) begin
                    r_suffix_len <= r_suffix_len + 2'd1;
                end
            end
        end
    end

    // Suffix characters, only the first two are kept
    always_ff @(posedge i_clk) begin
        if (take && !i_is_end && !is_digit && !r_suffix_len[1]) begin
            r_suffix_chars[r_suffix_len[0]] <= i_ch;
        end
    end

    // Terminator decode: status checks in priority order and scaling steps
    always_comb begin
        c0     = to_lower(r_suffix_chars[0]);
        c1     = to_lower(r_suffix_chars[1]);
        steps0 = unit_steps(c0);
        n_p0.value     = r_accum;
        n_p0.status    = ST_OK;
        n_p0.steps     = 3'd0;
        n_p0.base_1000 = 1'b0;
        if (r_digit_count == 5'd0) begin
            n_p0.status = ST_NO_DIGITS;
        end else if (r_suffix_len == 2'd3) begin
            n_p0.status = ST_SUFFIX_LONG;
        end else if (r_suffix_len == 2'd1) begin
            n_p0.steps = steps0;
            if (steps0 == 3'd0) begin
                n_p0.status = ST_BAD_SUFFIX;
            end
        end else if (r_suffix_len == 2'd2) begin
            n_p0.steps     = steps0;
            n_p0.base_1000 = 1'b1;
            if (steps0 == 3'd0 || c1 != 8'h62) begin
                n_p0.status = ST_BAD_SUFFIX;
            end
        end
        if (n_p0.status == ST_OK && r_accum_ovf) begin
            n_p0.status = ST_OVERFLOW;
        end
        if (n_p0.status != ST_OK) begin
            n_p0.value = 64'd0;
            n_p0.steps = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_valid <= 1'b0;
        end else if (o_ready) begin
            r_p0_valid <= i_valid && i_is_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_is_end) begin
            r_p0 <= n_p0;
        end
    end

    assign stg_valid[0] = r_p0_valid;
    assign stg_data[0]  = r_p0;

    // Scaling pipeline, one factor per stage
    for (genvar k = 1; k <= NumStages; k++) begin : g_scale
        ssp_scale_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[k-1]),
            .o_ready (stg_ready[k-1]),
            .i_data  (stg_data[k-1]),
            .o_valid (stg_valid[k]),
            .i_ready (stg_ready[k]),
            .o_data  (stg_data[k])
        );
    end

    // Output register
    assign out_valid            = stg_valid[NumStages];
    assign out_ready            = !r_out_valid || i_ready;
    assign stg_ready[NumStages] = out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && out_valid) begin
            r_out <= stg_data[NumStages];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_size_value = r_out.value;
    assign o_status     = r_out.status;

endmodule

// File: rtl/ssp_checker.sv
module ssp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [7:0]  i_ch,
    input logic        i_is_end,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_size_value,
    input logic [2:0]  o_status
);
    import ssp_pkg::*;

    // A waiting request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_ch) && $stable(i_is_end))
        else $error("request changed while waiting");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_size_value) && $stable(o_status))
        else $error("result changed while stalled");

    // Status code within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_OVERFLOW)
        else $error("status code out of range");

    // Any error carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_size_value == 64'd0)
        else $error("nonzero value with error status");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind size_string_parser ssp_checker u_ssp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_ch         (i_ch),
    .i_is_end     (i_is_end),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_size_value (o_size_value),
    .o_status     (o_status)
);

// File: sim/size_string_parser_tb.sv
module size_string_parser_tb;
    import ssp_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 140;
    localparam int unsigned RX_HOLD_CYCLES = 150;
    localparam int unsigned DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic [63:0] value;
        logic [2:0]  status;
    } t_size_result;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        i_valid  = 1'b0;
    logic [7:0]  i_ch     = 8'h00;
    logic        i_is_end = 1'b0;
    logic        i_ready  = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [63:0] o_size_value;
    logic [2:0]  o_status;

    // Parser state as seen by the predictor
    logic        sp_in_suffix;
    logic [63:0] sp_accum;
    logic        sp_accum_ovf;
    int unsigned sp_digits;
    int unsigned sp_suffix_len;
    logic [7:0]  sp_suffix [2];

    t_size_result pending_sizes [$];
    logic [7:0]   outgoing [$];
    int unsigned  items_sent     = 0;
    int unsigned  mismatch_count = 0;
    logic         tx_eager = 1'b0;
    logic         rx_eager = 1'b0;
    logic         rx_hold  = 1'b0;

    size_string_parser dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_ch         (i_ch),
        .i_is_end     (i_is_end),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_size_value (o_size_value),
        .o_status     (o_status)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Idle lengths: mostly short, a few long
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    function automatic int unsigned pick_gap();
        if (tx_eager || $urandom_range(0, 9) < 6) begin
            return 0;
        end
        return idle_len();
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // Unit letter to multiplier; zero for anything that is not a unit
    function automatic logic [63:0] unit_scale(input logic [7:0] letter,
                                               input logic [63:0] base);
        case (letter)
            "k":     return base;
            "m":     return base * base;
            "g":     return base * base * base;
            "t":     return base * base * base * base;
            default: return 64'd0;
        endcase
    endfunction

    task automatic clear_parse_state();
        sp_in_suffix  = 1'b0;
        sp_accum      = 64'd0;
        sp_accum_ovf  = 1'b0;
        sp_digits     = 0;
        sp_suffix_len = 0;
    endtask

    // Result of the string collected so far, in precedence order
    function automatic t_size_result scaled_size();
        t_size_result res;
        logic [63:0]  mult;
        logic [127:0] product;
        res = '0;
        if (sp_digits == 0) begin
            res.status = ST_NO_DIGITS;
        end else if (sp_suffix_len >= 3) begin
            res.status = ST_SUFFIX_LONG;
        end else begin
            mult = 64'd1;
            if (sp_suffix_len == 1) begin
                mult = unit_scale(fold_case(sp_suffix[0]), 64'd1024);
            end else if (sp_suffix_len == 2) begin
                if (fold_case(sp_suffix[1]) == "b") begin
                    mult = unit_scale(fold_case(sp_suffix[0]), 64'd1000);
                end else begin
                    mult = 64'd0;
                end
            end
            product = {64'd0, sp_accum} * {64'd0, mult};
            if (mult == 64'd0) begin
                res.status = ST_BAD_SUFFIX;
            end else if (sp_accum_ovf || product[127:64] != 64'd0) begin
                res.status = ST_OVERFLOW;
            end else begin
                res.status = ST_OK;
                res.value  = product[63:0];
            end
        end
        return res;
    endfunction

    // Advance the predictor by one accepted request
    task automatic predict_char(input logic [7:0] c, input logic is_end);
        logic [67:0] widened;
        if (!is_end) begin
            if (!sp_in_suffix && sp_digits < MaxDigits && c >= "0" && c <= "9") begin
                widened = {4'd0, sp_accum} * 68'd10 + {60'd0, c - 8'h30};
                if (widened[67:64] != 4'd0) begin
                    sp_accum_ovf = 1'b1;
                    sp_accum     = '1;
                end else begin
                    sp_accum = widened[63:0];
                end
                sp_digits++;
            end else begin
                sp_in_suffix = 1'b1;
                if (sp_suffix_len < 2) begin
                    sp_suffix[sp_suffix_len[0]] = c;
                end
                if (sp_suffix_len < 3) begin
                    sp_suffix_len++;
                end
            end
        end else begin
            pending_sizes.push_back(scaled_size());
            clear_parse_state();
        end
    endtask

    // Offer one request; returns right after the edge that accepts it
    task automatic send_char(input logic [7:0] c, input logic is_end);
        int unsigned gap;
        logic        rdy;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_ch     <= c;
        i_is_end <= is_end;
        // ready is sampled mid-cycle, where it holds the value seen at the next edge
        do begin
            @(negedge i_clk);
            rdy = o_ready;
            @(posedge i_clk);
        end while (!rdy);
        predict_char(c, is_end);
        items_sent++;
    endtask

    // Send the queued characters, then a terminator carrying a junk byte
    task automatic send_outgoing();
        foreach (outgoing[i]) begin
            send_char(outgoing[i], 1'b0);
        end
        outgoing.delete();
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            outgoing.push_back(s[i]);
        end
        send_outgoing();
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_sizes.size() != 0) @(posedge i_clk);
    endtask

    task automatic append_digits(input int unsigned count);
        repeat (count) outgoing.push_back("0" + 8'($urandom_range(0, 9)));
    endtask

    // Optional unit: none, one letter, or letter plus b, random case
    task automatic append_unit();
        string       units;
        int unsigned pick;
        logic [7:0]  letter;
        units = "kmgt";
        pick  = $urandom_range(0, 8);
        if (pick > 0) begin
            letter = units[(pick - 1) % 4];
            if ($urandom_range(0, 1)) begin
                letter = letter - 8'd32;
            end
            outgoing.push_back(letter);
            if (pick > 4) begin
                letter = "b";
                if ($urandom_range(0, 1)) begin
                    letter = "B";
                end
                outgoing.push_back(letter);
            end
        end
    endtask

    // Mostly well-formed sizes, some noise and broken strings
    task automatic send_random_string();
        int unsigned kind;
        int unsigned r;
        string       boundary;
        kind = $urandom_range(0, 99);
        r    = $urandom_range(0, 99);
        if (kind < 78) begin
            if (r < 65) begin
                append_digits($urandom_range(1, 4));
            end else if (r < 90) begin
                append_digits($urandom_range(5, 12));
            end else begin
                append_digits($urandom_range(13, 20));
            end
            append_unit();
        end else if (kind < 86) begin
            repeat ($urandom_range(0, 6)) outgoing.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 92) begin
            append_digits($urandom_range(1, 6));
            repeat ($urandom_range(1, 3)) outgoing.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 96) begin
            // digits resuming after a unit letter
            append_digits($urandom_range(1, 3));
            append_unit();
            append_digits($urandom_range(1, 2));
        end else begin
            // right at the 64-bit decimal boundary
            boundary = "1844674407370955161";
            for (int i = 0; i < 19; i++) begin
                outgoing.push_back(boundary[i]);
            end
            append_digits(1);
            if ($urandom_range(0, 2) == 0) begin
                append_unit();
            end
        end
        send_outgoing();
    endtask

    task automatic test_empty_and_zero();
        send_text("");
        send_text("0");
        send_text("7");
        send_text("0TB");
        send_text("x123");
        send_text("k");
        send_text("kb");
        outgoing.push_back(8'h00);
        send_outgoing();
        wait_for_results();
    endtask

    task automatic test_value_extremes();
        send_text("18446744073709551615");
        send_text("18446744073709551616");
        send_text("99999999999999999999");
        // 21st digit falls into the suffix
        send_text("123456789012345678901");
        send_text("00000000000000000001k");
        // unknown suffix and too-long suffix win over overflow
        send_text("99999999999999999999z");
        send_text("99999999999999999999kbb");
        wait_for_results();
    endtask

    task automatic test_unit_suffixes();
        send_text("1k");
        send_text("2M");
        send_text("3g");
        send_text("4T");
        send_text("5kb");
        send_text("6MB");
        send_text("7gB");
        send_text("8Tb");
        // product just fits, then just overflows
        send_text("16777215T");
        send_text("16777216t");
        send_text("18446744073709551kB");
        wait_for_results();
    endtask

    task automatic test_bad_suffixes();
        send_text("1x");
        send_text("1kx");
        send_text("1bk");
        send_text("1kbx");
        send_text("1k2");
        send_text("1b");
        outgoing.push_back("1");
        outgoing.push_back(8'h00);
        send_outgoing();
        outgoing.push_back("9");
        outgoing.push_back(8'hff);
        outgoing.push_back("b");
        send_outgoing();
        wait_for_results();
    endtask

    // Random strings, with a stretch in the middle where nobody idles
    task automatic test_random_strings();
        int unsigned stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            if (items_sent > stop_at - RANDOM_ITEMS * 2 / 3 &&
                items_sent < stop_at - RANDOM_ITEMS / 3) begin
                tx_eager = 1'b1;
                rx_eager = 1'b1;
            end else begin
                tx_eager = 1'b0;
                rx_eager = 1'b0;
            end
            send_random_string();
        end
        tx_eager = 1'b0;
        rx_eager = 1'b0;
        wait_for_results();
    endtask

    // Result side holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        rx_hold  = 1'b1;
        tx_eager = 1'b1;
        repeat (12) send_random_string();
        tx_eager = 1'b0;
        wait_for_results();
    endtask

    // Result side ready pattern
    initial begin : result_sink
        int unsigned busy;
        busy = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
                i_ready <= 1'b1;
            end else if (busy > 0) begin
                busy--;
                i_ready <= 1'b0;
            end else if (!rx_eager && $urandom_range(0, 3) == 0) begin
                busy = idle_len() - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest expected size
    always @(posedge i_clk) begin : size_check
        t_size_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_sizes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: value %0d status %0d",
                             o_size_value, o_status);
                end
            end else begin
                want = pending_sizes.pop_front();
                if (o_size_value !== want.value || o_status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                                 want.value, want.status, o_size_value, o_status);
                    end
                end
            end
        end
    end

    initial begin
        clear_parse_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_zero();
        test_value_extremes();
        test_unit_suffixes();
        test_bad_suffixes();
        test_backpressure();
        test_random_strings();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_sizes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: sim.f
rtl/ssp_pkg.sv
rtl/ssp_scale_stage.sv
rtl/size_string_parser.sv
rtl/ssp_checker.sv
sim/size_string_parser_tb.sv
